// File: rtl/fapm_pkg.sv
`default_nettype none

package fapm_pkg;

   // CSR port geometry: six 32-bit registers at byte offsets 4*i
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam int TIMER_W = 24;
   localparam int ELAPSED_W = 16;
   localparam int SAMPLE_W = 32;
   localparam int COUNT_W = 8;

   // operating modes
   localparam logic [1:0] MODE_DISABLED = 2'd0;
   localparam logic [1:0] MODE_MONITOR  = 2'd1;
   localparam logic [1:0] MODE_COMMS    = 2'd2;

   // register indexes (paddr[4:2])
   localparam logic [2:0] REG_MODE          = 3'd0;
   localparam logic [2:0] REG_FAULT_ENABLE  = 3'd1;
   localparam logic [2:0] REG_ALERT_ENABLE  = 3'd2;
   localparam logic [2:0] REG_ALARM_TIMEOUT = 3'd3;
   localparam logic [2:0] REG_FAULT_TIMEOUT = 3'd4;
   localparam logic [2:0] REG_RESET_TIMEOUT = 3'd5;

   typedef struct packed {
      logic [ELAPSED_W-1:0] elapsed_ms;
      logic                 fault_met;
      logic                 alarm_met;
      logic                 reset_met;
      logic [SAMPLE_W-1:0]  sample_word;
   } req_type;

   typedef struct packed {
      logic               fault_active;
      logic               alarm_active;
      logic               shutdown;
      logic               comms_ok;
      logic               fault_raised;
      logic               alarm_raised;
      logic               cleared;
      logic [COUNT_W-1:0] fault_total;
      logic [COUNT_W-1:0] alarm_total;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/fault_alarm_persistence_monitor.sv
`default_nettype none

// Fault / alarm persistence monitor.
// req channel: one transaction per monitoring tick (elapsed ms, fault/alarm/reset
//   condition flags, sample word). Accepted when req_valid is high and req_stall low.
// rsp channel: exactly one result transaction per tick, showing the latch state,
//   shutdown, comms status, per-tick raise/clear strobes and the event counts.
// Pipeline: an accepted tick passes through the input register, then the result
//   register written by the single-pass tick logic.
// Throughput: one tick per cycle while rsp_stall is low; the tick logic is one
//   add/subtract/compare layer per timer, and all state is committed when a tick
//   leaves the input register, so the next tick sees it in the following cycle.
// Stall: a stalled result holds in the output register while one more tick waits
//   in the input register; req_stall rises only when both are occupied.
// Reset (synchronous): pipeline empties, registers return to mode disabled,
//   fault and alert enables set, timeouts zero; timers, latches, counts zero,
//   comms_ok set.
// CSR: APB-style, pready tied high, writes land on the access cycle; only write
//   while no tick is in flight.
module fault_alarm_persistence_monitor (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  fapm_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output fapm_pkg::rsp_type            rsp_data,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire  [fapm_pkg::CSR_AW-1:0]  paddr,
   input  wire  [fapm_pkg::CSR_DW-1:0]  pwdata,
   output logic [fapm_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready
);
   import fapm_pkg::*;

   // ---------------- configuration registers ----------------
   logic [1:0]         mode_ff, mode_in;
   logic               fault_en_ff, fault_en_in;
   logic               alert_en_ff, alert_en_in;
   logic [TIMER_W-1:0] alarm_to_ff, alarm_to_in;
   logic [TIMER_W-1:0] fault_to_ff, fault_to_in;
   logic [TIMER_W-1:0] reset_to_ff, reset_to_in;

   logic       csr_wr;
   logic [2:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = paddr[4:2];

   always_comb begin
      mode_in     = mode_ff;
      fault_en_in = fault_en_ff;
      alert_en_in = alert_en_ff;
      alarm_to_in = alarm_to_ff;
      fault_to_in = fault_to_ff;
      reset_to_in = reset_to_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_MODE:          mode_in     = pwdata[1:0];
            REG_FAULT_ENABLE:  fault_en_in = pwdata[0];
            REG_ALERT_ENABLE:  alert_en_in = pwdata[0];
            REG_ALARM_TIMEOUT: alarm_to_in = pwdata[TIMER_W-1:0];
            REG_FAULT_TIMEOUT: fault_to_in = pwdata[TIMER_W-1:0];
            REG_RESET_TIMEOUT: reset_to_in = pwdata[TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MODE:          prdata = {{(CSR_DW-2){1'b0}}, mode_ff};
         REG_FAULT_ENABLE:  prdata = {{(CSR_DW-1){1'b0}}, fault_en_ff};
         REG_ALERT_ENABLE:  prdata = {{(CSR_DW-1){1'b0}}, alert_en_ff};
         REG_ALARM_TIMEOUT: prdata = {{(CSR_DW-TIMER_W){1'b0}}, alarm_to_ff};
         REG_FAULT_TIMEOUT: prdata = {{(CSR_DW-TIMER_W){1'b0}}, fault_to_ff};
         REG_RESET_TIMEOUT: prdata = {{(CSR_DW-TIMER_W){1'b0}}, reset_to_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_DISABLED;
         fault_en_ff <= 1'b1;
         alert_en_ff <= 1'b1;
         alarm_to_ff <= '0;
         fault_to_ff <= '0;
         reset_to_ff <= '0;
      end else begin
         mode_ff     <= mode_in;
         fault_en_ff <= fault_en_in;
         alert_en_ff <= alert_en_in;
         alarm_to_ff <= alarm_to_in;
         fault_to_ff <= fault_to_in;
         reset_to_ff <= reset_to_in;
      end
   end

   // ---------------- pipeline control ----------------
   // Stage 1 holds the accepted tick; the tick is evaluated and its state
   // committed as it moves into the result register.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    advance, accept, fire;

   assign advance     = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall   = s1_valid_ff & ~advance;
   assign accept      = req_valid & ~req_stall;
   assign fire        = s1_valid_ff & advance;
   assign s1_valid_in = accept | (s1_valid_ff & ~advance);
   assign rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) s1_data_ff  <= req_data;
      if (fire)   rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- monitor state ----------------
   logic [TIMER_W-1:0]  alarm_timer_ff, alarm_timer_in;
   logic [TIMER_W-1:0]  fault_timer_ff, fault_timer_in;
   logic [TIMER_W-1:0]  reset_timer_ff, reset_timer_in;
   logic                alarm_seen_ff, alarm_seen_in;
   logic                fault_seen_ff, fault_seen_in;
   logic                reset_seen_ff, reset_seen_in;
   logic                shutdown_ff, shutdown_in;
   logic                released_ff, released_in;
   logic                comms_ff, comms_in;
   logic [SAMPLE_W-1:0] last_sample_ff, last_sample_in;
   logic [COUNT_W-1:0]  fault_cnt_ff, fault_cnt_in;
   logic [COUNT_W-1:0]  alarm_cnt_ff, alarm_cnt_in;

   // tick decode
   logic [TIMER_W-1:0] elapsed;
   logic               mon, com, same_sample;
   logic               do_fault, do_alarm, do_reset;

   assign elapsed     = {{(TIMER_W-ELAPSED_W){1'b0}}, s1_data_ff.elapsed_ms};
   assign mon         = (mode_ff == MODE_MONITOR);
   assign com         = (mode_ff == MODE_COMMS);
   assign same_sample = (s1_data_ff.sample_word == last_sample_ff);
   assign do_fault    = com ? same_sample : (fault_en_ff & s1_data_ff.fault_met);
   assign do_alarm    = mon & s1_data_ff.alarm_met;
   assign do_reset    = com ? ~same_sample : s1_data_ff.reset_met;

   // countdowns, floored at zero
   logic [TIMER_W-1:0] ft_dn, at_dn, rt_dn;
   logic [TIMER_W-1:0] ft_d, at_d;

   assign ft_dn = (fault_timer_ff > elapsed) ? fault_timer_ff - elapsed : '0;
   assign at_dn = (alarm_timer_ff > elapsed) ? alarm_timer_ff - elapsed : '0;
   assign rt_dn = (reset_timer_ff > elapsed) ? reset_timer_ff - elapsed : '0;
   assign ft_d  = do_fault ? ft_dn : fault_timer_ff;
   assign at_d  = do_alarm ? at_dn : alarm_timer_ff;

   // refill of a timer that may have just counted down: down-then-up by the
   // same elapsed is max(timer, elapsed), so no subtract feeds the add
   logic [TIMER_W:0]   ft_sum, at_sum;
   logic [TIMER_W-1:0] ft_pre, at_pre, ft_up, at_up;

   assign ft_sum = {1'b0, fault_timer_ff} + {1'b0, elapsed};
   assign at_sum = {1'b0, alarm_timer_ff} + {1'b0, elapsed};
   assign ft_pre = (fault_timer_ff > elapsed) ? fault_timer_ff : elapsed;
   assign at_pre = (alarm_timer_ff > elapsed) ? alarm_timer_ff : elapsed;

   always_comb begin
      if (do_fault) begin
         ft_up = (ft_pre > fault_to_ff) ? fault_to_ff : ft_pre;
      end else begin
         ft_up = (ft_sum > {1'b0, fault_to_ff}) ? fault_to_ff : ft_sum[TIMER_W-1:0];
      end
      if (do_alarm) begin
         at_up = (at_pre > alarm_to_ff) ? alarm_to_ff : at_pre;
      end else begin
         at_up = (at_sum > {1'b0, alarm_to_ff}) ? alarm_to_ff : at_sum[TIMER_W-1:0];
      end
   end

   // latch events; all tests use the flags as they were at tick start
   logic fault_latch, alarm_latch, reset_latch, sd_release;

   assign fault_latch = do_fault & (ft_d == '0) & ~fault_seen_ff;
   assign alarm_latch = do_alarm & (at_d == '0) & ~alarm_seen_ff;
   assign reset_latch = do_reset & (rt_dn == '0) & ~reset_seen_ff;
   assign sd_release  = mon & ~fault_en_ff & ~released_ff;

   always_comb begin
      alarm_timer_in = alarm_timer_ff;
      fault_timer_in = fault_timer_ff;
      reset_timer_in = reset_timer_ff;
      alarm_seen_in  = alarm_seen_ff;
      fault_seen_in  = fault_seen_ff;
      reset_seen_in  = reset_seen_ff;
      shutdown_in    = shutdown_ff;
      released_in    = released_ff;
      comms_in       = comms_ff;
      last_sample_in = last_sample_ff;
      fault_cnt_in   = fault_cnt_ff;
      alarm_cnt_in   = alarm_cnt_ff;

      if (mon | com) begin
         if (com) last_sample_in = s1_data_ff.sample_word;
         if (mon) released_in = ~fault_en_ff;

         // timers
         fault_timer_in = ft_d;
         alarm_timer_in = at_d;
         if (do_reset & (ft_d < fault_to_ff)) begin
            fault_timer_in = mon ? ft_up : fault_to_ff;
         end
         if (do_reset & mon & (at_d < alarm_to_ff)) alarm_timer_in = at_up;
         if (do_reset & (reset_timer_ff != '0)) begin
            reset_timer_in = rt_dn;
         end else if (fault_latch | alarm_latch) begin
            reset_timer_in = reset_to_ff;
         end

         // latches
         if (fault_latch) begin
            fault_seen_in = 1'b1;
         end else if (reset_latch & fault_seen_ff) begin
            fault_seen_in = 1'b0;
         end
         if (alarm_latch) begin
            alarm_seen_in = 1'b1;
         end else if (reset_latch & mon & alarm_seen_ff) begin
            alarm_seen_in = 1'b0;
         end
         if (reset_latch) begin
            reset_seen_in = 1'b1;
         end else if (fault_latch | alarm_latch) begin
            reset_seen_in = 1'b0;
         end

         // shutdown / comms status: later steps of the tick win
         if (reset_latch) begin
            shutdown_in = 1'b0;
         end else if (fault_latch) begin
            shutdown_in = 1'b1;
         end else if (sd_release) begin
            shutdown_in = 1'b0;
         end
         if (com & reset_latch) begin
            comms_in = 1'b1;
         end else if (com & fault_latch) begin
            comms_in = 1'b0;
         end

         // event counts, saturating both ways
         if (alert_en_ff) begin
            if (fault_latch & (fault_cnt_ff != '1)) begin
               fault_cnt_in = fault_cnt_ff + 1'b1;
            end else if (reset_latch & fault_seen_ff & (fault_cnt_ff != '0)) begin
               fault_cnt_in = fault_cnt_ff - 1'b1;
            end
            if (alarm_latch & (alarm_cnt_ff != '1)) begin
               alarm_cnt_in = alarm_cnt_ff + 1'b1;
            end else if (reset_latch & mon & alarm_seen_ff & (alarm_cnt_ff != '0)) begin
               alarm_cnt_in = alarm_cnt_ff - 1'b1;
            end
         end
      end else begin
         // disabled (and the unused mode code)
         alarm_timer_in = alarm_to_ff;
         fault_timer_in = fault_to_ff;
         reset_timer_in = reset_to_ff;
         alarm_seen_in  = 1'b0;
         fault_seen_in  = 1'b0;
         reset_seen_in  = 1'b0;
      end
   end

   always_comb begin
      rsp_data_in.fault_active = fault_seen_in;
      rsp_data_in.alarm_active = alarm_seen_in;
      rsp_data_in.shutdown     = shutdown_in;
      rsp_data_in.comms_ok     = comms_in;
      rsp_data_in.fault_raised = (mon | com) & fault_latch;
      rsp_data_in.alarm_raised = (mon | com) & alarm_latch;
      rsp_data_in.cleared      = (mon | com) & reset_latch;
      rsp_data_in.fault_total  = fault_cnt_in;
      rsp_data_in.alarm_total  = alarm_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_timer_ff <= '0;
         fault_timer_ff <= '0;
         reset_timer_ff <= '0;
         alarm_seen_ff  <= 1'b0;
         fault_seen_ff  <= 1'b0;
         reset_seen_ff  <= 1'b0;
         shutdown_ff    <= 1'b0;
         released_ff    <= 1'b0;
         comms_ff       <= 1'b1;
         last_sample_ff <= '0;
         fault_cnt_ff   <= '0;
         alarm_cnt_ff   <= '0;
      end else if (fire) begin
         alarm_timer_ff <= alarm_timer_in;
         fault_timer_ff <= fault_timer_in;
         reset_timer_ff <= reset_timer_in;
         alarm_seen_ff  <= alarm_seen_in;
         fault_seen_ff  <= fault_seen_in;
         reset_seen_ff  <= reset_seen_in;
         shutdown_ff    <= shutdown_in;
         released_ff    <= released_in;
         comms_ff       <= comms_in;
         last_sample_ff <= last_sample_in;
         fault_cnt_ff   <= fault_cnt_in;
         alarm_cnt_ff   <= alarm_cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/fapm_checker.sv
`default_nettype none

module fapm_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input fapm_pkg::rsp_type            rsp_data
);
   import fapm_pkg::*;

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a latch raised on a tick is visible in that tick's result
   a_fault_raise: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault_raised |-> rsp_data.fault_active)
      else $error("fault raised without latch");

   a_alarm_raise: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.alarm_raised |-> rsp_data.alarm_active)
      else $error("alarm raised without latch");

   // a clear always drops the shutdown request
   a_clear_sd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cleared |-> !rsp_data.shutdown)
      else $error("shutdown survived clear");

endmodule

bind fault_alarm_persistence_monitor fapm_checker u_fapm_checker (.*);

`default_nettype wire
